[rtl/rme_pkg.sv]
package rme_pkg;

  localparam int unsigned WINDOW_MAX_DEF  = 32;
  localparam int unsigned SAMPLE_BITS_DEF = 24;

  localparam int unsigned LEN_W      = 6;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned CEIL_W     = 24;
  localparam int unsigned OUT_W      = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned FRAC_BITS  = 8;

  localparam int unsigned LEN_RESET  = 20;
  localparam int unsigned GAIN_RESET = 256;
  localparam int unsigned CEIL_RESET = 256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH = 2'd0,
    CFG_GAIN          = 2'd1,
    CFG_CEILING       = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVICT,
    ST_INSERT,
    ST_MEDIAN,
    ST_MUL,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;      // latch the accepted sample
    logic evict;     // drop the oldest word from the sorted list
    logic insert;    // add the new word to ring and sorted list
    logic median;    // pick the median and form the excess
    logic mul;       // scale by gain
    logic out_load;  // clamp and load the output register
  } cmd_t;

  typedef struct packed {
    logic full;
  } status_t;

endpackage

[rtl/rme_ram.sv]
module rme_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/rme_ctrl.sv]
module rme_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  rme_pkg::status_t status_i,
  output rme_pkg::cmd_t    cmd_o
);

  import rme_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  cmd_t   cmd;
  logic   in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = status_i.full ? ST_EVICT : ST_INSERT;
        end
      end
      ST_EVICT: begin
        cmd.evict = 1'b1;
        state_d   = ST_INSERT;
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
        state_d    = ST_MEDIAN;
      end
      ST_MEDIAN: begin
        cmd.median = 1'b1;
        state_d    = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free or being drained
        if (!out_valid_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

[rtl/rme_dp.sv]
module rme_dp #(
  parameter int unsigned WINDOW_MAX  = rme_pkg::WINDOW_MAX_DEF,
  parameter int unsigned SAMPLE_BITS = rme_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rme_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rme_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [SAMPLE_BITS-1:0]         sample_i,
  input  rme_pkg::cmd_t                  cmd_i,
  output rme_pkg::status_t               status_o,
  output logic [rme_pkg::OUT_W-1:0]      excess_o
);

  import rme_pkg::*;

  localparam int unsigned CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int unsigned IDX_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned LW     = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int unsigned PROD_W = SAMPLE_BITS + GAIN_W;
  localparam int unsigned SCL_W  = PROD_W - FRAC_BITS;
  localparam int unsigned CMP_W  = (SCL_W > OUT_W) ? SCL_W : OUT_W;
  localparam int unsigned LEN_INIT = (LEN_RESET > WINDOW_MAX) ? WINDOW_MAX : LEN_RESET;

  logic [CNT_W-1:0]       len_q;
  logic [GAIN_W-1:0]      gain_q;
  logic [CEIL_W-1:0]      ceil_q;
  logic [CNT_W-1:0]       count_q;
  logic [IDX_W-1:0]       oldest_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [SAMPLE_BITS-1:0] sorted_q [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0] rm_d     [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0] ins_d    [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0] diff_q, diff_d;
  logic [PROD_W-1:0]      prod_q;
  logic [OUT_W-1:0]       excess_q, excess_d;

  logic                   full;
  logic [CNT_W-1:0]       live;
  logic [WINDOW_MAX-1:0]  gt;
  logic [SAMPLE_BITS-1:0] old_word;
  logic [IDX_W-1:0]       waddr;
  logic [IDX_W-1:0]       med_idx;
  logic [SAMPLE_BITS-1:0] med;
  logic [CMP_W-1:0]       scl_ext, ceil_ext;
  logic [LW-1:0]          len_ext;
  logic [CNT_W-1:0]       len_clamped;

  assign full = (count_q == len_q);

  // zero acts as one, anything above the window size saturates
  always_comb begin
    len_ext = LW'(cfg_data_i[LEN_W-1:0]);
    if (len_ext == '0) begin
      len_clamped = CNT_W'(1);
    end else if (len_ext > LW'(WINDOW_MAX)) begin
      len_clamped = CNT_W'(WINDOW_MAX);
    end else begin
      len_clamped = CNT_W'(len_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= CNT_W'(LEN_INIT);
      gain_q   <= GAIN_W'(GAIN_RESET);
      ceil_q   <= CEIL_W'(CEIL_RESET);
      count_q  <= '0;
      oldest_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_WINDOW_LENGTH: begin
          len_q    <= len_clamped;
          count_q  <= '0;
          oldest_q <= '0;
        end
        CFG_GAIN:    gain_q <= cfg_data_i[GAIN_W-1:0];
        CFG_CEILING: ceil_q <= cfg_data_i[CEIL_W-1:0];
        default: begin
        end
      endcase
    end else if (cmd_i.insert) begin
      if (full) begin
        oldest_q <= (CNT_W'(oldest_q) + CNT_W'(1) == len_q) ? '0 : oldest_q + IDX_W'(1);
      end else begin
        count_q <= count_q + CNT_W'(1);
      end
    end
  end

  // Ring of raw samples; only needed to know which word leaves the window.
  // While filling, the oldest slot stays at zero, so the fill count is the slot.
  assign waddr = full ? oldest_q : IDX_W'(count_q);

  rme_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.insert),
    .waddr_i (waddr),
    .wdata_i (sample_q),
    .raddr_i (oldest_q),
    .rdata_o (old_word)
  );

  // Sorted list: every cell looks only at itself and its neighbors.
  assign live = full ? count_q - CNT_W'(1) : count_q;

  always_comb begin
    for (int i = 0; i < WINDOW_MAX; i++) begin
      gt[i] = (CNT_W'(i) < live) && (sorted_q[i] > sample_q);
    end
    for (int i = 0; i < WINDOW_MAX; i++) begin
      // cells at or above the leaving word close the gap
      rm_d[i] = sorted_q[i];
      if (i + 1 < WINDOW_MAX) begin
        if (sorted_q[i] >= old_word) begin
          rm_d[i] = sorted_q[(i + 1 < WINDOW_MAX) ? i + 1 : i];
        end
      end
      // cells above the new word move up by one
      if ((CNT_W'(i) < live) && !gt[i]) begin
        ins_d[i] = sorted_q[i];
      end else if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
        ins_d[i] = sorted_q[(i > 0) ? i - 1 : 0];
      end else begin
        ins_d[i] = sample_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.evict) begin
      sorted_q <= rm_d;
    end else if (cmd_i.insert) begin
      sorted_q <= ins_d;
    end
  end

  // upper median for an even count
  assign med_idx = IDX_W'(count_q >> 1);
  assign med     = sorted_q[med_idx];
  assign diff_d  = (sample_q > med) ? sample_q - med : '0;

  assign scl_ext  = CMP_W'(prod_q[PROD_W-1:FRAC_BITS]);
  assign ceil_ext = CMP_W'(ceil_q);
  assign excess_d = (scl_ext > ceil_ext) ? OUT_W'(ceil_q) : OUT_W'(scl_ext);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= sample_i;
    end
    if (cmd_i.median) begin
      diff_q <= diff_d;
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(diff_q) * PROD_W'(gain_q);
    end
    if (cmd_i.out_load) begin
      excess_q <= excess_d;
    end
  end

  assign status_o.full = full;
  assign excess_o      = excess_q;

endmodule

[rtl/running_median_excess.sv]
// Sliding-window median excess filter.
// Input channel (in_valid_i/in_ready_o, power_sample_i): one unsigned Q16.8
// frame-power word per handshake. Output channel (out_valid_o/out_ready_i,
// excess_o): one word per input, how far the sample lies above the median of
// the newest window_length samples, times gain (Q8.8), clamped to ceiling.
// Config channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i): index 0
// window_length (clears the history), 1 gain, 2 ceiling; other indexes are
// ignored. Always ready; write only while no word is in flight.
// One word is processed at a time by a five-step sequencer: evict the oldest
// word from a register-based sorted list, insert the new one, pick the median,
// multiply, clamp. The evict step is skipped while the window is filling. The
// sequencer returns to idle and takes the next word in the cycle after the
// result is loaded, so no new word is taken while one is being processed.
// If the receiver stalls, the result waits in the output register and one
// more word may be accepted and processed; it then holds in the last step.
// Reset: window_length 20 (saturated to WINDOW_MAX), gain 1.0, ceiling 1.0,
// empty history, no result pending.
module running_median_excess #(
  parameter int unsigned WINDOW_MAX  = rme_pkg::WINDOW_MAX_DEF,
  parameter int unsigned SAMPLE_BITS = rme_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [SAMPLE_BITS-1:0]         power_sample_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [rme_pkg::OUT_W-1:0]      excess_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rme_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rme_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import rme_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  rme_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rme_dp #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (power_sample_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .excess_o    (excess_o)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word accepted while one is in flight");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || out_ready_i))
    else $error("pending result overwritten");

  a_single_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.evict, cmd.insert, cmd.median, cmd.mul, cmd.out_load}))
    else $error("more than one datapath step in a cycle");

  a_evict_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.evict |-> $past(cmd.load))
    else $error("eviction without a fresh ring read");

endmodule

[tb/sv/tb_running_median_excess.sv]
module tb_running_median_excess;
  import rme_pkg::*;

  localparam int unsigned CLK_PERIOD     = 20;
  localparam int unsigned TIMEOUT_CYCLES = 200000;
  localparam int unsigned WIN_MAX        = WINDOW_MAX_DEF;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned EXP_DEPTH      = 64;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  logic [23:0]           power_sample_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i    = 1'b0;
  logic [OUT_W-1:0]      excess_o;
  logic                  cfg_valid_i    = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;

  running_median_excess DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .power_sample_i(power_sample_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .excess_o      (excess_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Shadow of the filter state
  logic [23:0]     win_hist [WIN_MAX];
  int unsigned     win_fill;
  int unsigned     win_oldest;
  int unsigned     win_len;
  logic [15:0]     gain_reg;
  logic [23:0]     ceil_reg;

  // Expected results, written at input accept and read at output accept
  logic [OUT_W-1:0] exp_fifo [EXP_DEPTH];
  int unsigned      exp_wr = 0;
  int unsigned      exp_rd = 0;

  int unsigned n_samples    = 0;
  int unsigned n_results    = 0;
  int unsigned n_cfg_writes = 0;
  int unsigned n_fail       = 0;
  int unsigned rx_hold_cycles = 0;
  bit          burst_mode   = 1'b0;
  logic [23:0] level;

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  function automatic int unsigned pending();
    return exp_wr - exp_rd;
  endfunction

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("timeout: %0d results still expected", pending());
    $display("FAIL running_median_excess");
    $finish;
  end

  function automatic int unsigned clamp_len(input logic [5:0] v);
    if (v == 0) return 1;
    if (v > WIN_MAX) return WIN_MAX;
    return 32'(v);
  endfunction

  function automatic void clear_window();
    win_fill   = 0;
    win_oldest = 0;
  endfunction

  // Store the word in the ring, rank the window and form the clamped excess
  function automatic logic [OUT_W-1:0] predict_excess(input logic [23:0] s);
    logic [23:0] sorted [WIN_MAX];
    logic [23:0] v;
    logic [23:0] med;
    logic [23:0] diff;
    logic [39:0] prod;
    logic [31:0] scaled;
    int          j;
    if (win_fill < win_len) begin
      win_hist[(win_oldest + win_fill) % WIN_MAX] = s;
      win_fill++;
    end else begin
      win_hist[win_oldest % WIN_MAX] = s;
      win_oldest = (win_oldest + 1) % win_len;
    end
    for (int i = 0; i < win_fill; i++) begin
      v = win_hist[i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    med    = sorted[win_fill / 2];
    diff   = (s > med) ? s - med : 24'd0;
    prod   = diff * gain_reg;
    scaled = prod[39:8];
    return (scaled > ceil_reg) ? ceil_reg : scaled[23:0];
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_WINDOW_LENGTH: begin
        win_len = clamp_len(data[5:0]);
        clear_window();
      end
      CFG_GAIN:    gain_reg = data[15:0];
      CFG_CEILING: ceil_reg = data;
      default: ;
    endcase
    n_cfg_writes++;
    @(posedge clk_i);
  endtask

  // Hold valid across back-to-back words; lower it only when a gap is drawn
  task automatic send_sample(input logic [23:0] s);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    power_sample_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    exp_fifo[exp_wr[5:0]] = predict_excess(s);
    exp_wr++;
    n_samples++;
  endtask

  // Drop valid, wait out every pending word plus the pipeline depth
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [23:0] draw_sample();
    int unsigned pick;
    int          offs;
    int          val;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2, 3: return 24'($urandom());
      default: begin
        offs = $urandom_range(0, 2047) - 1024;
        val  = int'(level) + offs;
        if (val < 0) val = 0;
        if (val > 24'hFFFFFF) val = 24'hFFFFFF;
        return val[23:0];
      end
    endcase
  endfunction

  // Receiver: random stall per word, long hold-off on request
  initial begin
    int unsigned gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
      end
      gap = burst_mode ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o && rx_hold_cycles == 0);
    end
  end

  always @(posedge clk_i) begin
    logic [OUT_W-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (pending() == 0) begin
        if (n_fail < MAX_REPORTS)
          $display("unexpected word: excess_o=%h", excess_o);
        n_fail++;
      end else begin
        want = exp_fifo[exp_rd[5:0]];
        exp_rd++;
        if (excess_o !== want) begin
          if (n_fail < MAX_REPORTS)
            $display("mismatch at result %0d: expected excess %h, got %h",
                     n_results, want, excess_o);
          n_fail++;
        end
      end
    end
  end

  task automatic test_reset_defaults();
    send_sample(24'h000000);
    send_sample(24'hFFFFFF);
    send_sample(24'h000001);
    send_sample(24'h800000);
    send_sample(24'h7FFFFF);
    send_sample(24'h000100);
    send_sample(24'hFFFFFF);
    settle();
  endtask

  task automatic test_directed_regs();
    // index outside the register map is ignored, history kept
    write_reg(CFG_UNUSED_IDX, 24'hFFFFFF);
    send_sample(24'h000200);
    settle();
    // zero length behaves as one: median is the sample itself
    write_reg(CFG_WINDOW_LENGTH, 24'hFFFFC0);
    send_sample(24'hFFFFFF);
    send_sample(24'h000000);
    settle();
    // oversized length saturates; full gain and ceiling force the clamp
    write_reg(CFG_GAIN, 24'hFFFFFF);
    write_reg(CFG_CEILING, 24'hFFFFFF);
    write_reg(CFG_WINDOW_LENGTH, 24'h00003F);
    send_sample(24'h000000);
    send_sample(24'h000000);
    send_sample(24'hFFFFFF);
    send_sample(24'h123456);
    settle();
    write_reg(CFG_CEILING, 24'h000000);
    send_sample(24'hFFFFFF);
    send_sample(24'hFFFFFF);
    settle();
    write_reg(CFG_CEILING, 24'hFFFFFF);
    write_reg(CFG_GAIN, 24'h000000);
    send_sample(24'hFFFFFF);
    send_sample(24'h000001);
    settle();
    write_reg(CFG_GAIN, 24'h000100);
    write_reg(CFG_WINDOW_LENGTH, 24'h000001);
    send_sample(24'h000010);
    send_sample(24'hFFFFF0);
    settle();
  endtask

  task automatic test_random_windows();
    logic [5:0]  len;
    logic [15:0] g;
    logic [23:0] c;
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin len = 6'd32; g = 16'h0100; c = 24'hFFFFFF; end
        1: begin len = 6'd1;  g = 16'hFFFF; c = 24'hFFFFFF; end
        2: begin len = 6'd2;  g = 16'h0080; c = 24'h00FFFF; end
        3: begin len = 6'd0;  g = 16'h0001; c = 24'hFFFFFF; end
        4: begin len = 6'd63; g = 16'h0300; c = 24'h000000; end
        default: begin
          len = 6'($urandom_range(0, 63));
          g   = 16'($urandom());
          c   = ($urandom_range(0, 3) == 0) ? 24'($urandom()) : 24'hFFFFFF;
        end
      endcase
      write_reg(CFG_GAIN, (24'($urandom()) & 24'hFF0000) | {8'h00, g});
      write_reg(CFG_CEILING, c);
      if (p % 3 != 2)
        write_reg(CFG_WINDOW_LENGTH, (24'($urandom()) & 24'hFFFFC0) | {18'h0, len});
      level = 24'($urandom());
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(0, 15) == 0) level = 24'($urandom());
        send_sample(draw_sample());
      end
      settle();
    end
  endtask

  task automatic test_backpressure();
    write_reg(CFG_WINDOW_LENGTH, 24'h000008);
    write_reg(CFG_GAIN, 24'h000200);
    level = 24'h400000;
    rx_hold_cycles = 80;
    for (int i = 0; i < 14; i++) send_sample(draw_sample());
    // pause the source until the output side has caught up
    in_valid_i <= 1'b0;
    while (pending() != 0) @(posedge clk_i);
    for (int i = 0; i < 10; i++) send_sample(draw_sample());
    settle();
  endtask

  task automatic test_back_to_back();
    write_reg(CFG_WINDOW_LENGTH, 24'h000011);
    burst_mode = 1'b1;
    level = 24'($urandom());
    for (int i = 0; i < 40; i++) send_sample(draw_sample());
    settle();
    burst_mode = 1'b0;
  endtask

  initial begin
    win_len  = clamp_len(6'(LEN_RESET));
    gain_reg = 16'(GAIN_RESET);
    ceil_reg = 24'(CEIL_RESET);
    clear_window();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_directed_regs();
    test_random_windows();
    test_backpressure();
    test_back_to_back();

    settle();
    repeat (20) @(posedge clk_i);
    if (pending() != 0) begin
      $display("%0d expected results never arrived", pending());
      n_fail++;
    end
    $display("run covered %0d samples, %0d results, %0d register writes", n_samples,
             n_results, n_cfg_writes);
    $display("window lengths 0..63 incl. saturation, gain/ceiling extremes, stalls");
    if (n_fail == 0) begin
      $display("PASS running_median_excess");
    end else begin
      $display("%0d failures", n_fail);
      $display("FAIL running_median_excess");
    end
    $finish;
  end

endmodule
